>>> sv/sac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_pkg: shared types and constants for the suffix automaton cover check
// Capacities, field widths, payload structs and transition row helpers.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int MAX_STATES = 1048576;
    localparam int MAX_QUERY  = 1048576;
    localparam int ALPHABET   = 3;

    localparam int STATE_W = $clog2(MAX_STATES);
    localparam int CNT_W   = $clog2(MAX_STATES + 1);
    localparam int POS_W   = $clog2(MAX_QUERY + 2);
    localparam int QADDR_W = $clog2(MAX_QUERY + 1);
    localparam int ROW_W   = STATE_W * ALPHABET;
    localparam int LEN_W   = 21;
    localparam int SYM_W   = 2;

    localparam logic [SYM_W-1:0] SYM_SEP = SYM_W'(2);

    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } in_item_t;

    typedef struct packed {
        logic             verdict;
        logic [LEN_W-1:0] covered;
        logic [LEN_W-1:0] query_length;
        logic             overflow;
    } out_item_t;

    // pick one edge out of a transition row
    function automatic logic [STATE_W-1:0] edge_get(input logic [ROW_W-1:0] row,
                                                    input logic [SYM_W-1:0] sym);
        logic [STATE_W-1:0] res;
        res = '0;
        for (int a = 0; a < ALPHABET; a++)
        begin
            if (sym == SYM_W'(a))
            begin
                res = row[a*STATE_W +: STATE_W];
            end
        end
        return res;
    endfunction

    // replace one edge of a transition row
    function automatic logic [ROW_W-1:0] edge_set(input logic [ROW_W-1:0] row,
                                                  input logic [SYM_W-1:0] sym,
                                                  input logic [STATE_W-1:0] tgt);
        logic [ROW_W-1:0] res;
        res = row;
        for (int a = 0; a < ALPHABET; a++)
        begin
            if (sym == SYM_W'(a))
            begin
                res[a*STATE_W +: STATE_W] = tgt;
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> sv/sac_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sac_ram: generic simple dual-port memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> sv/suffix_automaton_cover_check.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// suffix_automaton_cover_check: suffix automaton build and query coverage
// Text transfers extend the automaton, query transfers track the longest
// match and run a monotone deque cover program; the last query symbol
// yields one result transfer.
// ----------------------------------------------------------------------------
// One item is worked on at a time and in_ready is low while it runs. All
// automaton and query state sits in single-port-read memories, so each
// step issues at most one read per memory. A text symbol adds a new state,
// walks the suffix links adding edges to it and, when the walk stops at an
// existing edge, either links to that edge's target or clones it and
// redirects edges to the clone. A query symbol follows its match, falling
// back along suffix links, then pops dominated deque entries, pushes the new
// one and advances the deque head; before the first full piece fits it skips
// the deque. The last query symbol then reads the result for the output.
// After reset the block writes the root state before it takes the first item.
module suffix_automaton_cover_check (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire sac_pkg::in_item_t       in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output sac_pkg::out_item_t           out_data,
    input  wire logic                    cfg_we,
    input  wire logic [sac_pkg::LEN_W-1:0] cfg_wdata
);
    import sac_pkg::*;

    localparam logic [4:0] S_INIT   = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] E_START  = 5'd2;
    localparam logic [4:0] E_LEN    = 5'd3;
    localparam logic [4:0] E_WALK   = 5'd4;
    localparam logic [4:0] E_LP     = 5'd5;
    localparam logic [4:0] E_LQ     = 5'd6;
    localparam logic [4:0] E_W2     = 5'd7;
    localparam logic [4:0] E_FIX1   = 5'd8;
    localparam logic [4:0] E_FIX2   = 5'd9;
    localparam logic [4:0] Q_RD     = 5'd10;
    localparam logic [4:0] Q_CHK    = 5'd11;
    localparam logic [4:0] Q_LEN    = 5'd12;
    localparam logic [4:0] D_PREV   = 5'd13;
    localparam logic [4:0] D_J      = 5'd14;
    localparam logic [4:0] D_JD     = 5'd15;
    localparam logic [4:0] D_POP    = 5'd16;
    localparam logic [4:0] D_POPI   = 5'd17;
    localparam logic [4:0] D_POPC   = 5'd18;
    localparam logic [4:0] D_PUSH   = 5'd19;
    localparam logic [4:0] D_HEAD   = 5'd20;
    localparam logic [4:0] D_HEADI  = 5'd21;
    localparam logic [4:0] D_CAND   = 5'd22;
    localparam logic [4:0] D_WR     = 5'd23;
    localparam logic [4:0] F_RD     = 5'd24;
    localparam logic [4:0] F_OUT    = 5'd25;

    // control registers
    logic [4:0]         state_reg, state_next;
    logic [CNT_W-1:0]   st_cnt_reg, st_cnt_next;
    logic [STATE_W-1:0] tail_reg, tail_next;
    logic [STATE_W-1:0] ms_reg, ms_next;
    logic [POS_W-1:0]   ml_reg, ml_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [QADDR_W-1:0] head_reg, head_next;
    logic [QADDR_W-1:0] dqt_reg, dqt_next;
    logic               ovf_reg, ovf_next;
    logic [LEN_W-1:0]   min_len_reg;
    logic               out_valid_reg, out_valid_next;

    // working registers
    logic [STATE_W-1:0] p_reg, p_next;
    logic [STATE_W-1:0] cur_reg, cur_next;
    logic [STATE_W-1:0] q_reg, q_next;
    logic [STATE_W-1:0] cl_reg, cl_next;
    logic [STATE_W-1:0] lenp_reg, lenp_next;
    logic [SYM_W-1:0]   sym_reg, sym_next;
    logic               last_reg, last_next;
    logic [QADDR_W-1:0] j_reg, j_next;
    logic [LEN_W-1:0]   covj_reg, covj_next;
    logic [LEN_W-1:0]   covi_reg, covi_next;
    logic [QADDR_W-1:0] k_reg, k_next;
    out_item_t          out_data_reg, out_data_next;

    // memory ports
    logic               len_we, link_we, trans_we, cover_we, dq_we;
    logic [STATE_W-1:0] len_waddr, len_raddr, len_wdata, len_rdata;
    logic [STATE_W-1:0] link_waddr, link_raddr, link_wdata, link_rdata;
    logic [STATE_W-1:0] trans_waddr, trans_raddr;
    logic [ROW_W-1:0]   trans_wdata, trans_rdata;
    logic [QADDR_W-1:0] cover_waddr, cover_raddr;
    logic [LEN_W-1:0]   cover_wdata, cover_rdata;
    logic [QADDR_W-1:0] dq_waddr, dq_raddr, dq_wdata, dq_rdata;

    // combinational helpers
    logic [STATE_W-1:0] row_edge;
    logic [LEN_W-1:0]   piece_len;
    logic [POS_W:0]     pop_lhs, pop_rhs, head_sum, cand_sum;
    logic [LEN_W+3:0]   cov_x10, len_x9;
    logic [POS_W-1:0]   fin_n;

    sac_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    sac_ram #(.WIDTH(STATE_W), .DEPTH(MAX_STATES)) u_link_ram (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    sac_ram #(.WIDTH(ROW_W), .DEPTH(MAX_STATES)) u_trans_ram (
        .clk(clk), .we(trans_we), .waddr(trans_waddr), .wdata(trans_wdata),
        .raddr(trans_raddr), .rdata(trans_rdata)
    );

    sac_ram #(.WIDTH(LEN_W), .DEPTH(MAX_QUERY + 1)) u_cover_ram (
        .clk(clk), .we(cover_we), .waddr(cover_waddr), .wdata(cover_wdata),
        .raddr(cover_raddr), .rdata(cover_rdata)
    );

    sac_ram #(.WIDTH(QADDR_W), .DEPTH(MAX_QUERY + 1)) u_dq_ram (
        .clk(clk), .we(dq_we), .waddr(dq_waddr), .wdata(dq_wdata),
        .raddr(dq_raddr), .rdata(dq_rdata)
    );

    // shared datapath terms
    assign row_edge  = edge_get(trans_rdata, sym_reg);
    assign piece_len = (min_len_reg == '0) ? LEN_W'(1) : min_len_reg;
    assign pop_lhs   = {1'b0, cover_rdata} + {1'b0, j_reg};
    assign pop_rhs   = {1'b0, covj_reg} + {1'b0, k_reg};
    assign head_sum  = {1'b0, k_reg} + {1'b0, ml_reg};
    assign cand_sum  = {1'b0, cover_rdata} + {1'b0, pos_reg} - {1'b0, k_reg};
    assign fin_n     = pos_reg - POS_W'(1);
    assign cov_x10   = {cover_rdata, 3'b000} + {2'b00, cover_rdata, 1'b0};
    assign len_x9    = {fin_n, 3'b000} + {3'b000, fin_n};

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        st_cnt_next    = st_cnt_reg;
        tail_next      = tail_reg;
        ms_next        = ms_reg;
        ml_next        = ml_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        dqt_next       = dqt_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        p_next         = p_reg;
        cur_next       = cur_reg;
        q_next         = q_reg;
        cl_next        = cl_reg;
        lenp_next      = lenp_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        j_next         = j_reg;
        covj_next      = covj_reg;
        covi_next      = covi_reg;
        k_next         = k_reg;
        out_data_next  = out_data_reg;

        len_we = 1'b0;   len_waddr = '0;   len_wdata = '0;   len_raddr = '0;
        link_we = 1'b0;  link_waddr = '0;  link_wdata = '0;  link_raddr = '0;
        trans_we = 1'b0; trans_waddr = '0; trans_wdata = '0; trans_raddr = '0;
        cover_we = 1'b0; cover_waddr = '0; cover_wdata = '0; cover_raddr = '0;
        dq_we = 1'b0;    dq_waddr = '0;    dq_wdata = '0;    dq_raddr = '0;

        case (state_reg)
            // root state and empty cover prefix
            S_INIT:
            begin
                len_we   = 1'b1;
                link_we  = 1'b1;
                trans_we = 1'b1;
                cover_we = 1'b1;
                state_next = S_IDLE;
            end

            // take a transfer and dispatch
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sym_next  = in_data.symbol;
                    last_next = in_data.last;
                    if (!in_data.op)
                    begin
                        if (in_data.symbol >= SYM_W'(ALPHABET))
                        begin
                            state_next = S_IDLE;
                        end
                        else if (st_cnt_reg > CNT_W'(MAX_STATES - 2))
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            state_next = E_START;
                        end
                    end
                    else if (pos_reg > POS_W'(MAX_QUERY))
                    begin
                        ovf_next   = 1'b1;
                        state_next = in_data.last ? F_RD : S_IDLE;
                    end
                    else if (in_data.symbol >= SYM_SEP)
                    begin
                        ms_next    = '0;
                        ml_next    = '0;
                        state_next = D_PREV;
                    end
                    else
                    begin
                        state_next = Q_RD;
                    end
                end
            end

            // new state for the appended symbol
            E_START:
            begin
                cur_next    = st_cnt_reg[STATE_W-1:0];
                st_cnt_next = st_cnt_reg + CNT_W'(1);
                trans_we    = 1'b1;
                trans_waddr = st_cnt_reg[STATE_W-1:0];
                link_we     = 1'b1;
                link_waddr  = st_cnt_reg[STATE_W-1:0];
                len_raddr   = tail_reg;
                state_next  = E_LEN;
            end

            E_LEN:
            begin
                len_we      = 1'b1;
                len_waddr   = cur_reg;
                len_wdata   = len_rdata + STATE_W'(1);
                p_next      = tail_reg;
                trans_raddr = tail_reg;
                link_raddr  = tail_reg;
                state_next  = E_WALK;
            end

            // suffix-link walk adding edges to the new state
            E_WALK:
            begin
                if (row_edge == '0)
                begin
                    trans_we    = 1'b1;
                    trans_waddr = p_reg;
                    trans_wdata = edge_set(trans_rdata, sym_reg, cur_reg);
                    if (p_reg == '0)
                    begin
                        tail_next  = cur_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        p_next      = link_rdata;
                        trans_raddr = link_rdata;
                        link_raddr  = link_rdata;
                    end
                end
                else
                begin
                    q_next     = row_edge;
                    len_raddr  = p_reg;
                    state_next = E_LP;
                end
            end

            E_LP:
            begin
                lenp_next   = len_rdata;
                len_raddr   = q_reg;
                trans_raddr = q_reg;
                link_raddr  = q_reg;
                state_next  = E_LQ;
            end

            // solid edge or clone
            E_LQ:
            begin
                if (lenp_reg + STATE_W'(1) == len_rdata)
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = q_reg;
                    tail_next  = cur_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    cl_next     = st_cnt_reg[STATE_W-1:0];
                    st_cnt_next = st_cnt_reg + CNT_W'(1);
                    len_we      = 1'b1;
                    len_waddr   = st_cnt_reg[STATE_W-1:0];
                    len_wdata   = lenp_reg + STATE_W'(1);
                    link_we     = 1'b1;
                    link_waddr  = st_cnt_reg[STATE_W-1:0];
                    link_wdata  = link_rdata;
                    trans_we    = 1'b1;
                    trans_waddr = st_cnt_reg[STATE_W-1:0];
                    trans_wdata = trans_rdata;
                    trans_raddr = p_reg;
                    link_raddr  = p_reg;
                    state_next  = E_W2;
                end
            end

            // redirect edges from the old state to the clone
            E_W2:
            begin
                if (row_edge == q_reg)
                begin
                    trans_we    = 1'b1;
                    trans_waddr = p_reg;
                    trans_wdata = edge_set(trans_rdata, sym_reg, cl_reg);
                    if (p_reg == '0)
                    begin
                        state_next = E_FIX1;
                    end
                    else
                    begin
                        p_next      = link_rdata;
                        trans_raddr = link_rdata;
                        link_raddr  = link_rdata;
                    end
                end
                else
                begin
                    state_next = E_FIX1;
                end
            end

            E_FIX1:
            begin
                link_we    = 1'b1;
                link_waddr = q_reg;
                link_wdata = cl_reg;
                state_next = E_FIX2;
            end

            E_FIX2:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg;
                link_wdata = cl_reg;
                tail_next  = cur_reg;
                state_next = S_IDLE;
            end

            // match tracking
            Q_RD:
            begin
                trans_raddr = ms_reg;
                link_raddr  = ms_reg;
                state_next  = Q_CHK;
            end

            Q_CHK:
            begin
                if (ms_reg != '0 && row_edge == '0)
                begin
                    ms_next    = link_rdata;
                    len_raddr  = link_rdata;
                    state_next = Q_LEN;
                end
                else
                begin
                    if (row_edge != '0)
                    begin
                        ml_next = ml_reg + POS_W'(1);
                        ms_next = row_edge;
                    end
                    state_next = D_PREV;
                end
            end

            Q_LEN:
            begin
                ml_next    = POS_W'(len_rdata);
                state_next = Q_RD;
            end

            // cover program
            D_PREV:
            begin
                cover_raddr = QADDR_W'(pos_reg - POS_W'(1));
                state_next  = D_J;
            end

            D_J:
            begin
                covi_next = cover_rdata;
                if (pos_reg >= POS_W'(piece_len))
                begin
                    j_next      = QADDR_W'(pos_reg - POS_W'(piece_len));
                    cover_raddr = QADDR_W'(pos_reg - POS_W'(piece_len));
                    state_next  = D_JD;
                end
                else
                begin
                    state_next = D_WR;
                end
            end

            D_JD:
            begin
                covj_next  = cover_rdata;
                state_next = D_POP;
            end

            // drop dominated entries from the back
            D_POP:
            begin
                if (head_reg < dqt_reg)
                begin
                    dq_raddr   = dqt_reg - QADDR_W'(1);
                    state_next = D_POPI;
                end
                else
                begin
                    state_next = D_PUSH;
                end
            end

            D_POPI:
            begin
                k_next      = dq_rdata;
                cover_raddr = dq_rdata;
                state_next  = D_POPC;
            end

            D_POPC:
            begin
                if (pop_lhs <= pop_rhs)
                begin
                    dqt_next   = dqt_reg - QADDR_W'(1);
                    state_next = D_POP;
                end
                else
                begin
                    state_next = D_PUSH;
                end
            end

            D_PUSH:
            begin
                dq_we      = 1'b1;
                dq_waddr   = dqt_reg;
                dq_wdata   = j_reg;
                dqt_next   = dqt_reg + QADDR_W'(1);
                state_next = D_HEAD;
            end

            // drop entries outside the match window from the front
            D_HEAD:
            begin
                if (head_reg < dqt_reg)
                begin
                    dq_raddr   = head_reg;
                    state_next = D_HEADI;
                end
                else
                begin
                    state_next = D_WR;
                end
            end

            D_HEADI:
            begin
                k_next = dq_rdata;
                if ({1'b0, dq_rdata} + {1'b0, ml_reg} < {1'b0, pos_reg})
                begin
                    head_next  = head_reg + QADDR_W'(1);
                    state_next = D_HEAD;
                end
                else
                begin
                    cover_raddr = dq_rdata;
                    state_next  = D_CAND;
                end
            end

            D_CAND:
            begin
                if (head_sum >= {1'b0, pos_reg} && cand_sum[LEN_W-1:0] > covi_reg)
                begin
                    covi_next = cand_sum[LEN_W-1:0];
                end
                state_next = D_WR;
            end

            D_WR:
            begin
                cover_we    = 1'b1;
                cover_waddr = QADDR_W'(pos_reg);
                cover_wdata = covi_reg;
                pos_next    = pos_reg + POS_W'(1);
                state_next  = last_reg ? F_RD : S_IDLE;
            end

            // result of the finished query
            F_RD:
            begin
                cover_raddr = QADDR_W'(fin_n);
                state_next  = F_OUT;
            end

            F_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.verdict      = (cov_x10 >= len_x9);
                    out_data_next.covered      = cover_rdata;
                    out_data_next.query_length = LEN_W'(fin_n);
                    out_data_next.overflow     = ovf_reg;
                    pos_next   = POS_W'(1);
                    head_next  = '0;
                    dqt_next   = '0;
                    ms_next    = '0;
                    ml_next    = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cover_raddr = QADDR_W'(fin_n);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            st_cnt_reg    <= CNT_W'(1);
            tail_reg      <= '0;
            ms_reg        <= '0;
            ml_reg        <= '0;
            pos_reg       <= POS_W'(1);
            head_reg      <= '0;
            dqt_reg       <= '0;
            ovf_reg       <= 1'b0;
            min_len_reg   <= LEN_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            st_cnt_reg    <= st_cnt_next;
            tail_reg      <= tail_next;
            ms_reg        <= ms_next;
            ml_reg        <= ml_next;
            pos_reg       <= pos_next;
            head_reg      <= head_next;
            dqt_reg       <= dqt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                min_len_reg <= cfg_wdata;
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        p_reg        <= p_next;
        cur_reg      <= cur_next;
        q_reg        <= q_next;
        cl_reg       <= cl_next;
        lenp_reg     <= lenp_next;
        sym_reg      <= sym_next;
        last_reg     <= last_next;
        j_reg        <= j_next;
        covj_reg     <= covj_next;
        covi_reg     <= covi_next;
        k_reg        <= k_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

>>> tb/sv/suffix_automaton_cover_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suffix_automaton_cover_check_tb: self-checking bench for the cover check
// Builds small texts into the automaton, streams queries made of text
// fragments and noise, and checks every result transfer against an
// in-bench automaton and cover predictor, over several piece lengths.
// ----------------------------------------------------------------------------
module suffix_automaton_cover_check_tb;
    import sac_pkg::*;

    localparam int QCAP = 4096;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_ready;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [LEN_W-1:0]     cfg_wdata;

    // stimulus and expectations
    in_item_t             pending_items[$];
    out_item_t            expected_results[$];
    int unsigned          text_hist[$];
    int                   errors;
    bit                   quiet;
    int                   hold_serial;
    int                   hold_seen;
    int                   hold_left;
    int                   send_gap;
    int                   recv_gap;

    // predictor state
    int unsigned          sa_len[$];
    int unsigned          sa_link[$];
    int unsigned          sa_next[$];
    int unsigned          sa_tail;
    int unsigned          piece_len;
    int unsigned          cov_tab[QCAP];
    int unsigned          dq[QCAP];
    int unsigned          dq_head;
    int unsigned          dq_tail;
    int unsigned          m_state;
    int unsigned          m_len;
    int unsigned          q_pos;

    suffix_automaton_cover_check u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned add_state(int unsigned length);
        sa_len.push_back(length);
        sa_link.push_back(0);
        repeat (3) sa_next.push_back(0);
        return sa_len.size() - 1;
    endfunction

    // automaton extension by one text symbol
    function automatic void grow_automaton(int unsigned c);
        int unsigned cur, p, q, cl;
        bit have;
        have = 1'b1;
        cur = add_state(sa_len[sa_tail] + 1);
        p = sa_tail;
        while (have && sa_next[p*3+c] == 0)
        begin
            sa_next[p*3+c] = cur;
            if (p == 0) have = 1'b0; else p = sa_link[p];
        end
        if (have)
        begin
            q = sa_next[p*3+c];
            if (sa_len[p] + 1 == sa_len[q])
                sa_link[cur] = q;
            else
            begin
                cl = add_state(sa_len[p] + 1);
                sa_link[cl] = sa_link[q];
                for (int a = 0; a < 3; a++) sa_next[cl*3+a] = sa_next[q*3+a];
                while (have && sa_next[p*3+c] == q)
                begin
                    sa_next[p*3+c] = cl;
                    if (p == 0) have = 1'b0; else p = sa_link[p];
                end
                sa_link[q] = cl;
                sa_link[cur] = cl;
            end
        end
        sa_tail = cur;
    endfunction

    function automatic longint dq_key(int unsigned j);
        return longint'(cov_tab[j]) - longint'(j);
    endfunction

    // match tracking and deque cover step for one query symbol
    function automatic void cover_step(int unsigned sym);
        int unsigned i, plen, j, k, cand;
        i = q_pos;
        plen = (piece_len == 0) ? 1 : piece_len;
        if (sym >= 2)
        begin
            m_state = 0;
            m_len = 0;
        end
        else
        begin
            while (m_state != 0 && sa_next[m_state*3+sym] == 0)
            begin
                m_state = sa_link[m_state];
                m_len = sa_len[m_state];
            end
            if (sa_next[m_state*3+sym] != 0)
            begin
                m_len++;
                m_state = sa_next[m_state*3+sym];
            end
        end
        cov_tab[i] = cov_tab[i-1];
        if (i >= plen)
        begin
            j = i - plen;
            while (dq_head < dq_tail && dq_key(dq[dq_tail-1]) <= dq_key(j)) dq_tail--;
            dq[dq_tail] = j;
            dq_tail++;
            while (dq_head < dq_tail && longint'(dq[dq_head]) < longint'(i) - longint'(m_len))
                dq_head++;
            if (dq_head < dq_tail)
            begin
                k = dq[dq_head];
                cand = cov_tab[k] + (i - k);
                if (cand > cov_tab[i]) cov_tab[i] = cand;
            end
        end
        q_pos = i + 1;
    endfunction

    // expected result, if any, for one accepted item
    function automatic void predict_item(in_item_t it);
        int unsigned n;
        out_item_t r;
        if (!it.op)
        begin
            if (it.symbol < 3) grow_automaton(it.symbol);
            return;
        end
        cover_step(it.symbol);
        if (!it.last) return;
        n = q_pos - 1;
        r.verdict = (longint'(cov_tab[n]) * 10 >= longint'(n) * 9);
        r.covered = LEN_W'(cov_tab[n]);
        r.query_length = LEN_W'(n);
        r.overflow = 1'b0;
        expected_results.push_back(r);
        for (int x = 0; x <= n; x++) cov_tab[x] = 0;
        q_pos = 1;
        dq_head = 0;
        dq_tail = 0;
        m_state = 0;
        m_len = 0;
    endfunction

    // sender: transfers come from the pending queue
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || in_ready))
        begin
            if (in_valid) predict_item(in_data);
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                in_data <= pending_items.pop_front();
                in_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 5);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: checks result transfers and throttles out_ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transfer");
                    errors++;
                end
                else
                begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (out_data.verdict !== e.verdict)
                    begin
                        $error("verdict: expected %0d got %0d", e.verdict, out_data.verdict);
                        errors++;
                    end
                    if (out_data.covered !== e.covered)
                    begin
                        $error("covered: expected %0d got %0d", e.covered, out_data.covered);
                        errors++;
                    end
                    if (out_data.query_length !== e.query_length)
                    begin
                        $error("query_length: expected %0d got %0d",
                               e.query_length, out_data.query_length);
                        errors++;
                    end
                    if (out_data.overflow !== e.overflow)
                    begin
                        $error("overflow: expected %0d got %0d", e.overflow, out_data.overflow);
                        errors++;
                    end
                end
            end
            if (hold_serial != hold_seen)
            begin
                hold_seen <= hold_serial;
                hold_left <= 400;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                recv_gap <= $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic in_item_t mk(bit op, int unsigned sym, bit last);
        in_item_t it;
        it.op = op;
        it.symbol = SYM_W'(sym);
        it.last = last;
        return it;
    endfunction

    task automatic push_text(int unsigned sym);
        pending_items.push_back(mk(1'b0, sym, bit'($urandom_range(0, 1))));
        if (sym < 3) text_hist.push_back(sym);
    endtask

    task automatic push_query(int unsigned syms[$]);
        foreach (syms[x]) pending_items.push_back(mk(1'b1, syms[x], x == syms.size() - 1));
    endtask

    // random document: mostly binary, with separators and stray symbols
    task automatic add_document(int unsigned n);
        repeat (n)
        begin
            int unsigned r;
            r = $urandom_range(0, 19);
            push_text(r == 0 ? 2 : (r == 1 ? 3 : r % 2));
        end
        push_text(2);
    endtask

    // query built from text fragments with a little noise
    task automatic add_query();
        int unsigned syms[$];
        int unsigned want, st, fl;
        want = $urandom_range(1, 24);
        while (syms.size() < want)
        begin
            if ($urandom_range(0, 7) == 0 || text_hist.size() == 0)
                syms.push_back($urandom_range(0, 3));
            else
            begin
                st = $urandom_range(0, text_hist.size() - 1);
                fl = $urandom_range(1, 12);
                for (int x = 0; x < fl && st + x < text_hist.size(); x++)
                    syms.push_back(text_hist[st + x]);
            end
        end
        push_query(syms);
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_piece_len(logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        piece_len = v;
    endtask

    // stimulus sequence
    initial
    begin
        logic [LEN_W-1:0] lens[8];
        errors = 0;
        quiet = 1'b0;
        hold_serial = 0;
        hold_seen = 0;
        hold_left = 0;
        send_gap = 0;
        recv_gap = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        sa_tail = add_state(0);
        piece_len = 1;
        q_pos = 1;
        dq_head = 0;
        dq_tail = 0;
        m_state = 0;
        m_len = 0;
        for (int x = 0; x < QCAP; x++) cov_tab[x] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: separator, ignored symbol, piece at start, symbols 2 and 3
        push_text(0); push_text(1); push_text(0); push_text(2); push_text(1);
        push_text(1); push_text(3); push_text(0);
        push_query('{0, 1, 0});
        push_query('{1});
        push_query('{2, 3, 0, 1});
        push_query('{0, 0, 0, 1, 1, 0});
        push_query('{3});
        wait_idle();
        set_piece_len('0);
        push_query('{1, 1, 0, 2, 0});
        wait_idle();
        set_piece_len(LEN_MAX);
        push_query('{0, 1, 1});
        wait_idle();

        // random phases over several piece lengths
        lens = '{1, 2, 3, 4, 1048576, 0, 5, 2};
        foreach (lens[p])
        begin
            set_piece_len(lens[p]);
            add_document($urandom_range(5, 30));
            if (p == 3) hold_serial++;
            if (p == 7) quiet = 1'b1;
            repeat (3) add_query();
            wait_idle();
        end

        repeat (200)
        begin
            do @(posedge clk);
            while (expected_results.size() > 100 && !quiet);
            if (errors >= 0) break;
        end
        if (errors == 0)
            $display("suffix_automaton_cover_check_tb: PASS");
        else
            $display("suffix_automaton_cover_check_tb: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("suffix_automaton_cover_check_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
sv/sac_pkg.sv
sv/sac_ram.sv
sv/suffix_automaton_cover_check.sv
tb/sv/suffix_automaton_cover_check_tb.sv
